FILE: sv/gm3_pkg.sv
// Shared types and constants of the 3x3 grayscale min/max filter.
// Used by the pixel and result channel interfaces and by every module of the block.
package gm3_pkg;

    localparam int IMAGE_WIDTH  = 512;
    localparam int IMAGE_HEIGHT = 512;
    localparam int PIX_W  = 16;
    localparam int COL_W  = $clog2(IMAGE_WIDTH);
    localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
    localparam int PEND_W = $clog2(IMAGE_WIDTH + 2);

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [PEND_W-1:0] pend_t;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic OP_MIN = 1'b0;
    localparam logic OP_MAX = 1'b1;

    localparam col_t  LAST_COL  = col_t'(IMAGE_WIDTH - 1);
    localparam row_t  LAST_ROW  = row_t'(IMAGE_HEIGHT - 1);
    localparam pend_t FULL_PEND = pend_t'(IMAGE_WIDTH + 1);
    localparam pend_t LINE_PEND = pend_t'(IMAGE_WIDTH);

    // One column of the 3x3 window: bot is the newest line, top the oldest.
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } tap_col_t;

    // Line store controls driven by the sequencer.
    typedef struct packed {
        logic pix_acc;
        logic lb1_rd_en;
        col_t lb1_rd_addr;
        col_t col;
        col_t prev_col;
    } lb_ctl_t;

    // Control of the word held between the input and the result register.
    typedef struct packed {
        logic valid;
        logic flush;
        logic interior;
        logic last;
    } s1_ctl_t;

endpackage

FILE: sv/gm3_if.sv
// Channel interfaces of the 3x3 grayscale min/max filter.
// Depends on gm3_pkg for the field widths.
interface gm3_pix_if import gm3_pkg::*; ();
    logic valid;
    logic ready;
    logic kind;
    pix_t pixel_value;

    modport source(output valid, output kind, output pixel_value, input ready);
    modport sink(input valid, input kind, input pixel_value, output ready);
endinterface

interface gm3_res_if import gm3_pkg::*; ();
    logic valid;
    logic ready;
    pix_t pixel_out;
    logic last_out;

    modport source(output valid, output pixel_out, output last_out, input ready);
    modport sink(input valid, input pixel_out, input last_out, output ready);
endinterface

interface gm3_cfg_if;
    logic valid;
    logic ready;
    logic op_select;

    modport source(output valid, output op_select, input ready);
    modport sink(input valid, input op_select, output ready);
endinterface

FILE: sv/gm3_line_buf.sv
// One line of pixel storage: one write port and one registered read port.
// Depends on gm3_pkg for the line length and pixel width.
module gm3_line_buf import gm3_pkg::*;
(
    input  logic clk,
    input  logic wr_en,
    input  col_t wr_addr,
    input  pix_t wr_data,
    input  logic rd_en,
    input  col_t rd_addr,
    output pix_t rd_data
);

    pix_t mem [IMAGE_WIDTH];
    pix_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/gm3_ctrl.sv
// Sequencer: input handshake, frame position counters, pending count and
// the control of the word between the input stage and the result register.
// Depends on gm3_pkg and gm3_if.
module gm3_ctrl import gm3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gm3_pix_if.sink   pix,
    input  logic      out_free,
    output lb_ctl_t   lb_ctl,
    output s1_ctl_t   s1_ctl
);

    col_t    in_col_reg, in_col_next;
    row_t    in_row_reg, in_row_next;
    pend_t   pend_reg, pend_next;
    col_t    out_col_reg, out_col_next;
    row_t    out_row_reg, out_row_next;
    s1_ctl_t s1_reg, s1_next;

    logic word_acc;
    logic pix_acc;
    logic flush_acc;
    logic flush_hit;
    logic emit;

    assign pix.ready = !s1_reg.valid || out_free;

    always_comb
    begin
        word_acc  = pix.valid && pix.ready;
        pix_acc   = word_acc && (pix.kind == KIND_PIXEL);
        flush_acc = word_acc && (pix.kind == KIND_FLUSH);
        flush_hit = flush_acc && (in_col_reg == '0) && (in_row_reg == '0)
                    && (pend_reg != '0);
        emit      = (pix_acc && (pend_reg == FULL_PEND)) || flush_hit;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        pend_next    = pend_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        s1_next      = s1_reg;

        if (pix_acc)
        begin
            if (in_col_reg == LAST_COL)
            begin
                in_col_next = '0;
                in_row_next = (in_row_reg == LAST_ROW) ? '0 : row_t'(in_row_reg + 1'b1);
            end
            else
            begin
                in_col_next = col_t'(in_col_reg + 1'b1);
            end
            if (!emit)
            begin
                pend_next = pend_t'(pend_reg + 1'b1);
            end
        end

        if (flush_hit)
        begin
            pend_next = pend_t'(pend_reg - 1'b1);
        end

        if (emit)
        begin
            if (out_col_reg == LAST_COL)
            begin
                out_col_next = '0;
                out_row_next = (out_row_reg == LAST_ROW) ? '0 : row_t'(out_row_reg + 1'b1);
            end
            else
            begin
                out_col_next = col_t'(out_col_reg + 1'b1);
            end
        end

        if (word_acc)
        begin
            s1_next.valid    = emit;
            s1_next.flush    = flush_acc;
            s1_next.interior = pix_acc && (out_row_reg != '0) && (out_row_reg != LAST_ROW)
                               && (out_col_reg != '0) && (out_col_reg != LAST_COL);
            s1_next.last     = (out_row_reg == LAST_ROW) && (out_col_reg == LAST_COL);
        end
        else if (out_free)
        begin
            s1_next.valid = 1'b0;
        end
    end

    // A flush with one line plus one pixel pending takes its pixel from the word that the
    // last pixel read; any other flush reads the line store behind the frame end.
    always_comb
    begin
        lb_ctl.pix_acc     = pix_acc;
        lb_ctl.lb1_rd_en   = pix_acc || (flush_hit && (pend_reg != FULL_PEND));
        lb_ctl.lb1_rd_addr = pix_acc ? in_col_reg : col_t'(LINE_PEND - pend_reg);
        lb_ctl.col         = in_col_reg;
        lb_ctl.prev_col    = (in_col_reg == '0) ? LAST_COL : col_t'(in_col_reg - 1'b1);
    end

    assign s1_ctl = s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            pend_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            s1_reg      <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            pend_reg    <= pend_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            s1_reg      <= s1_next;
        end
    end

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= FULL_PEND)
        else $error("pending count above one line plus one pixel");

    a_pix_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_acc && (pend_reg == FULL_PEND)) |=>
            (s1_reg.valid && !s1_reg.flush && (pend_reg == FULL_PEND)))
        else $error("pixel with full window did not produce a result");

    a_flush_drain: assert property (@(posedge clk) disable iff (!rst_n)
        flush_hit |=> (s1_reg.valid && (pend_reg == pend_t'($past(pend_reg) - 1'b1))))
        else $error("flush at frame end did not drain one pending pixel");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_acc && (in_col_reg != LAST_COL)) |=> $stable(in_row_reg))
        else $error("input row moved inside a line");

    a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.valid && s1_reg.last) |-> !s1_reg.interior)
        else $error("final pixel of a frame marked as interior");

endmodule

FILE: sv/gm3_window.sv
// Window taps, 9-way min/max compare and the result register.
// Depends on gm3_pkg and gm3_if.
module gm3_window import gm3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tap_shift,
    input  pix_t      pixel_value,
    input  pix_t      lb1_q,
    input  pix_t      lb2_q,
    input  s1_ctl_t   s1_ctl,
    input  logic      op_select,
    output logic      out_free,
    gm3_res_if.source res
);

    pix_t     x_reg;
    tap_col_t col1_reg;
    tap_col_t col2_reg;
    tap_col_t col0;

    logic out_valid_reg, out_valid_next;
    pix_t out_pix_reg, out_pix_next;
    logic out_last_reg;

    pix_t l1_a, l1_b, l1_c, l1_d;
    pix_t l2_a, l2_b;
    pix_t l3_a;
    pix_t win_val;

    function automatic pix_t pick(input pix_t a, input pix_t b, input logic op);
        if (op == OP_MAX)
        begin
            return (a > b) ? a : b;
        end
        return (a < b) ? a : b;
    endfunction

    assign col0 = '{top: lb2_q, mid: lb1_q, bot: x_reg};

    always_ff @(posedge clk)
    begin
        if (tap_shift)
        begin
            x_reg    <= pixel_value;
            col1_reg <= col0;
            col2_reg <= col1_reg;
        end
    end

    always_comb
    begin
        l1_a    = pick(col0.top, col0.mid, op_select);
        l1_b    = pick(col0.bot, col1_reg.top, op_select);
        l1_c    = pick(col1_reg.bot, col2_reg.top, op_select);
        l1_d    = pick(col2_reg.mid, col2_reg.bot, op_select);
        l2_a    = pick(l1_a, l1_b, op_select);
        l2_b    = pick(l1_c, l1_d, op_select);
        l3_a    = pick(l2_a, l2_b, op_select);
        win_val = pick(l3_a, col1_reg.mid, op_select);
    end

    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_ctl.valid;
        end

        if (s1_ctl.interior)
        begin
            out_pix_next = win_val;
        end
        else if (s1_ctl.flush)
        begin
            out_pix_next = col0.mid;
        end
        else
        begin
            out_pix_next = col1_reg.mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_ctl.valid)
        begin
            out_pix_reg  <= out_pix_next;
            out_last_reg <= s1_ctl.last;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.pixel_out = out_pix_reg;
    assign res.last_out  = out_last_reg;

endmodule

FILE: sv/gray_morphology_3x3.sv
// Top level of the 3x3 grayscale min/max filter over a raster pixel stream.
// Depends on gm3_pkg, gm3_if, gm3_line_buf, gm3_ctrl and gm3_window.
//
//   channel  dir  fields                 word
//   pix      in   kind, pixel_value      one pixel or one flush
//   res      out  pixel_out, last_out    one filtered pixel
//   cfg      in   op_select              one write of the op register
//
// One word is accepted per cycle while pix.ready is high; a result is held in the
// word register beside the registered line store read, then in the result register.
// Reset clears counters, the pending count, valid flags and op_select; the line
// stores are not cleared. A stalled result register holds one word and the stage
// before it one more, after which pix.ready drops until the result is taken.
module gray_morphology_3x3 import gm3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    gm3_pix_if.sink  pix,
    gm3_res_if.source res,
    gm3_cfg_if.sink  cfg
);

    logic    op_select_reg;
    lb_ctl_t lb_ctl;
    s1_ctl_t s1_ctl;
    logic    out_free;
    pix_t    lb1_q;
    pix_t    lb2_q;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_select_reg <= OP_MIN;
        end
        else if (cfg.valid && cfg.ready)
        begin
            op_select_reg <= cfg.op_select;
        end
    end

    gm3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix      (pix),
        .out_free (out_free),
        .lb_ctl   (lb_ctl),
        .s1_ctl   (s1_ctl)
    );

    // The first line store delays the input by one line; the second is fed
    // from the first one pixel later, so its read lands two lines back.
    gm3_line_buf u_lb1 (
        .clk     (clk),
        .wr_en   (lb_ctl.pix_acc),
        .wr_addr (lb_ctl.col),
        .wr_data (pix.pixel_value),
        .rd_en   (lb_ctl.lb1_rd_en),
        .rd_addr (lb_ctl.lb1_rd_addr),
        .rd_data (lb1_q)
    );

    gm3_line_buf u_lb2 (
        .clk     (clk),
        .wr_en   (lb_ctl.pix_acc),
        .wr_addr (lb_ctl.prev_col),
        .wr_data (lb1_q),
        .rd_en   (lb_ctl.pix_acc),
        .rd_addr (lb_ctl.col),
        .rd_data (lb2_q)
    );

    gm3_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .tap_shift   (lb_ctl.pix_acc),
        .pixel_value (pix.pixel_value),
        .lb1_q       (lb1_q),
        .lb2_q       (lb2_q),
        .s1_ctl      (s1_ctl),
        .op_select   (op_select_reg),
        .out_free    (out_free),
        .res         (res)
    );

endmodule
